// ===== hw/rtl/ddo_pkg.sv =====
// Types, constants and tables shared by the differential drive odometry block.
package ddo_pkg;

  localparam logic [31:0] METRES_PER_TICK_RST  = 32'd8674200;
  localparam logic [31:0] TURN_PER_DIFF_RST    = 32'd73628000;
  localparam logic [31:0] RADIANS_PER_TICK_RST = 32'd24094700;

  localparam logic [1:0] REG_METRES_PER_TICK  = 2'd0;
  localparam logic [1:0] REG_TURN_PER_DIFF    = 2'd1;
  localparam logic [1:0] REG_RADIANS_PER_TICK = 2'd2;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;

  localparam logic [31:0] LIN_RATE_C   = 32'd1048576000;
  localparam int          LIN_RATE_S   = 41;
  localparam logic [31:0] TURN_RATE_C  = 32'd1647099329;
  localparam int          TURN_RATE_S  = 42;
  localparam logic [31:0] WHEEL_RATE_C = 32'd4194304000;
  localparam int          WHEEL_RATE_S = 38;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]        time_ms;
  } sample_t;

  typedef struct packed {
    logic signed [47:0] pose_x;
    logic signed [47:0] pose_y;
    logic signed [31:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] linear_rate;
    logic signed [31:0] turn_rate;
    logic signed [47:0] left_angle;
    logic signed [47:0] right_angle;
    logic signed [31:0] left_rate;
    logic signed [31:0] right_rate;
    logic               rates_fresh;
  } result_t;

  typedef struct packed {
    logic [1:0]  reg_index;
    logic [31:0] reg_value;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MLO, ST_MHI, ST_MSUM, ST_POST, ST_CWAIT1, ST_HEAD,
    ST_DIV, ST_RSAT, ST_CWAIT2, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_TRAVEL, OP_TURN, OP_LEFT_ANGLE, OP_RIGHT_ANGLE, OP_LEFT_MAG, OP_RIGHT_MAG,
    OP_POS_X, OP_POS_Y, OP_RATE_LIN, OP_RATE_TURN, OP_RATE_LEFT, OP_RATE_RIGHT
  } op_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/ddo_stream_if.sv =====
// Valid/ready channel carrying one payload per transfer.
interface ddo_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/differential_drive_odometry.sv =====
// Top level of the differential drive wheel odometry block.
//
//   channel  direction  payload             transfer
//   sample   in         ddo_pkg::sample_t   valid & ready
//   result   out        ddo_pkg::result_t   valid & ready
//   cfg      in         ddo_pkg::cfg_t      valid & ready (ready always high)
//
// When elapsed time is nonzero, each sample also runs four 64-step divisions for
// the rates; when it is zero, the divisions are skipped and the held rates stay.
// Each multiplication forms two 32 by 32 partial products (ST_MLO, ST_MHI) and sums them in ST_MSUM.
// Reset is synchronous; it restores the registers, the pose and the held rates.
// A finished result waits in the output register while the next sample is taken.
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic       clk,
  input  logic       rst,
  ddo_stream_if.sink   sample,
  ddo_stream_if.source result,
  ddo_stream_if.sink   cfg
);

  ddo_pkg::state_t state, state_next;
  ddo_pkg::op_t    op, op_next;

  logic [31:0] metres_per_tick, turn_per_diff, radians_per_tick;
  logic [31:0] last_left, last_right, last_time;
  logic signed [63:0] acc_x, acc_y;
  logic [39:0] acc_heading;
  logic signed [31:0] held [4];

  logic signed [31:0] cl, cr, dl, dr;
  logic [31:0] dt;
  logic        fresh;
  logic [63:0] travel, turn, wl, wr;
  logic [47:0] la, ra;
  logic [63:0] plo, phi;
  logic [95:0] wide;

  logic        accept;
  logic        cordic_start, cordic_busy;
  logic signed [31:0] cordic_angle;
  logic signed [33:0] cos_q30, sin_q30;
  logic        div_start, div_busy;
  logic [63:0] div_dividend, quotient;

  logic signed [32:0] sum33, diff33;
  logic [32:0] sum_mag, diff_mag;
  logic [31:0] cl_mag, cr_mag, dl_mag, dr_mag, cos_mag, sin_mag;
  logic [63:0] opa;
  logic [31:0] opb;
  logic [39:0] head_next;
  logic [63:0] wide_neg;
  logic        term_neg, rate_neg;
  logic signed [61:0] term;
  logic [31:0] rate_sat;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [61:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} + {{3{b[61]}}, b};
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] q);
    logic signed [34:0] t;
    logic signed [19:0] v;
    logic signed [15:0] r;
    t = {q[33], q} + 35'sd16384;
    v = 20'(t >>> 15);
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = state == ddo_pkg::ST_IDLE;
  assign cfg.ready    = 1'b1;

  always_comb begin
    sum33     = {dl[31], dl} + {dr[31], dr};
    diff33    = {dr[31], dr} - {dl[31], dl};
    sum_mag   = sum33[32] ? 33'(-sum33) : sum33;
    diff_mag  = diff33[32] ? 33'(-diff33) : diff33;
    cl_mag    = cl[31] ? 32'(-cl) : cl;
    cr_mag    = cr[31] ? 32'(-cr) : cr;
    dl_mag    = dl[31] ? 32'(-dl) : dl;
    dr_mag    = dr[31] ? 32'(-dr) : dr;
    cos_mag   = 32'(cos_q30[33] ? -cos_q30 : cos_q30);
    sin_mag   = 32'(sin_q30[33] ? -sin_q30 : sin_q30);
    head_next = diff33[32] ? acc_heading - turn[39:0] : acc_heading + turn[39:0];
    wide_neg  = -wide[63:0];
  end

  always_comb begin
    opa          = '0;
    opb          = '0;
    term_neg     = 1'b0;
    rate_neg     = 1'b0;
    div_dividend = '0;
    unique case (op)
      ddo_pkg::OP_TRAVEL: begin
        opa = 64'(sum_mag);
        opb = metres_per_tick;
      end
      ddo_pkg::OP_TURN: begin
        opa = 64'(diff_mag);
        opb = turn_per_diff;
      end
      ddo_pkg::OP_LEFT_ANGLE: begin
        opa = 64'(cl_mag);
        opb = radians_per_tick;
      end
      ddo_pkg::OP_RIGHT_ANGLE: begin
        opa = 64'(cr_mag);
        opb = radians_per_tick;
      end
      ddo_pkg::OP_LEFT_MAG: begin
        opa = 64'(dl_mag);
        opb = radians_per_tick;
      end
      ddo_pkg::OP_RIGHT_MAG: begin
        opa = 64'(dr_mag);
        opb = radians_per_tick;
      end
      ddo_pkg::OP_POS_X: begin
        opa      = travel;
        opb      = cos_mag;
        term_neg = sum33[32] ^ cos_q30[33];
      end
      ddo_pkg::OP_POS_Y: begin
        opa      = travel;
        opb      = sin_mag;
        term_neg = sum33[32] ^ sin_q30[33];
      end
      ddo_pkg::OP_RATE_LIN: begin
        opa          = travel;
        opb          = ddo_pkg::LIN_RATE_C;
        rate_neg     = sum33[32];
        div_dividend = 64'(wide >> ddo_pkg::LIN_RATE_S);
      end
      ddo_pkg::OP_RATE_TURN: begin
        opa          = turn;
        opb          = ddo_pkg::TURN_RATE_C;
        rate_neg     = diff33[32];
        div_dividend = 64'(wide >> ddo_pkg::TURN_RATE_S);
      end
      ddo_pkg::OP_RATE_LEFT: begin
        opa          = wl;
        opb          = ddo_pkg::WHEEL_RATE_C;
        rate_neg     = dl[31];
        div_dividend = 64'(wide >> ddo_pkg::WHEEL_RATE_S);
      end
      ddo_pkg::OP_RATE_RIGHT: begin
        opa          = wr;
        opb          = ddo_pkg::WHEEL_RATE_C;
        rate_neg     = dr[31];
        div_dividend = 64'(wide >> ddo_pkg::WHEEL_RATE_S);
      end
      default: begin
        opa = '0;
      end
    endcase
    term = term_neg ? -$signed({1'b0, wide[95:35]}) : $signed({1'b0, wide[95:35]});
    if (rate_neg) begin
      rate_sat = (quotient > 64'h8000_0000) ? 32'h8000_0000 : 32'(-quotient[31:0]);
    end else begin
      rate_sat = (quotient > 64'h7fff_ffff) ? 32'h7fff_ffff : quotient[31:0];
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      ddo_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = ddo_pkg::ST_MLO;
          op_next    = ddo_pkg::OP_TRAVEL;
        end
      end
      ddo_pkg::ST_MLO:  state_next = ddo_pkg::ST_MHI;
      ddo_pkg::ST_MHI:  state_next = ddo_pkg::ST_MSUM;
      ddo_pkg::ST_MSUM: state_next = ddo_pkg::ST_POST;
      ddo_pkg::ST_POST: begin
        case (op)
          ddo_pkg::OP_RIGHT_MAG: begin
            state_next = ddo_pkg::ST_CWAIT1;
            op_next    = ddo_pkg::OP_POS_X;
          end
          ddo_pkg::OP_POS_Y: state_next = ddo_pkg::ST_HEAD;
          ddo_pkg::OP_RATE_LIN, ddo_pkg::OP_RATE_TURN, ddo_pkg::OP_RATE_LEFT,
          ddo_pkg::OP_RATE_RIGHT: state_next = ddo_pkg::ST_DIV;
          default: begin
            state_next = ddo_pkg::ST_MLO;
            op_next    = ddo_pkg::op_t'(op + 4'd1);
          end
        endcase
      end
      ddo_pkg::ST_CWAIT1: begin
        if (!cordic_busy) begin
          state_next = ddo_pkg::ST_MLO;
        end
      end
      ddo_pkg::ST_HEAD: begin
        if (fresh) begin
          state_next = ddo_pkg::ST_MLO;
          op_next    = ddo_pkg::OP_RATE_LIN;
        end else begin
          state_next = ddo_pkg::ST_CWAIT2;
        end
      end
      ddo_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_next = ddo_pkg::ST_RSAT;
        end
      end
      ddo_pkg::ST_RSAT: begin
        if (op == ddo_pkg::OP_RATE_RIGHT) begin
          state_next = ddo_pkg::ST_CWAIT2;
        end else begin
          state_next = ddo_pkg::ST_MLO;
          op_next    = ddo_pkg::op_t'(op + 4'd1);
        end
      end
      ddo_pkg::ST_CWAIT2: begin
        if (!cordic_busy) begin
          state_next = ddo_pkg::ST_FIN;
        end
      end
      ddo_pkg::ST_FIN: begin
        if (!result.valid || result.ready) begin
          state_next = ddo_pkg::ST_IDLE;
        end
      end
      default: state_next = ddo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cordic_start = 1'b0;
    div_start    = 1'b0;
    cordic_angle = $signed(acc_heading[39:8]);
    unique case (state)
      ddo_pkg::ST_IDLE: cordic_start = accept;
      ddo_pkg::ST_HEAD: begin
        cordic_start = 1'b1;
        cordic_angle = $signed({head_next[39], head_next[39:9]});
      end
      ddo_pkg::ST_POST: begin
        div_start = op == ddo_pkg::OP_RATE_LIN || op == ddo_pkg::OP_RATE_TURN ||
                    op == ddo_pkg::OP_RATE_LEFT || op == ddo_pkg::OP_RATE_RIGHT;
      end
      default: cordic_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::ST_IDLE;
      op    <= ddo_pkg::OP_TRAVEL;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      metres_per_tick  <= ddo_pkg::METRES_PER_TICK_RST;
      turn_per_diff    <= ddo_pkg::TURN_PER_DIFF_RST;
      radians_per_tick <= ddo_pkg::RADIANS_PER_TICK_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.data.reg_index)
        ddo_pkg::REG_METRES_PER_TICK:  metres_per_tick  <= cfg.data.reg_value;
        ddo_pkg::REG_TURN_PER_DIFF:    turn_per_diff    <= cfg.data.reg_value;
        ddo_pkg::REG_RADIANS_PER_TICK: radians_per_tick <= cfg.data.reg_value;
        default: metres_per_tick <= metres_per_tick;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_left   <= '0;
      last_right  <= '0;
      last_time   <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
      for (int k = 0; k < 4; k++) begin
        held[k] <= '0;
      end
    end else begin
      if (accept) begin
        last_left  <= sample.data.left_count;
        last_right <= sample.data.right_count;
        last_time  <= sample.data.time_ms;
      end
      if (state == ddo_pkg::ST_POST && op == ddo_pkg::OP_POS_X) begin
        acc_x <= sat_add(acc_x, term);
      end
      if (state == ddo_pkg::ST_POST && op == ddo_pkg::OP_POS_Y) begin
        acc_y <= sat_add(acc_y, term);
      end
      if (state == ddo_pkg::ST_HEAD) begin
        acc_heading <= head_next;
      end
      if (state == ddo_pkg::ST_RSAT) begin
        case (op)
          ddo_pkg::OP_RATE_LIN:   held[0] <= rate_sat;
          ddo_pkg::OP_RATE_TURN:  held[1] <= rate_sat;
          ddo_pkg::OP_RATE_LEFT:  held[2] <= rate_sat;
          ddo_pkg::OP_RATE_RIGHT: held[3] <= rate_sat;
          default: held[0] <= held[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cl    <= sample.data.left_count;
      cr    <= sample.data.right_count;
      dl    <= sample.data.left_count - last_left;
      dr    <= sample.data.right_count - last_right;
      dt    <= sample.data.time_ms - last_time;
      fresh <= sample.data.time_ms != last_time;
    end
    unique case (state)
      ddo_pkg::ST_MLO:  plo  <= 64'(opa[31:0]) * 64'(opb);
      ddo_pkg::ST_MHI:  phi  <= 64'(opa[63:32]) * 64'(opb);
      ddo_pkg::ST_MSUM: wide <= {phi, 32'd0} + 96'(plo);
      ddo_pkg::ST_POST: begin
        case (op)
          ddo_pkg::OP_TRAVEL:      travel <= wide[63:0];
          ddo_pkg::OP_TURN:        turn   <= wide[63:0];
          ddo_pkg::OP_LEFT_ANGLE:  la     <= cl[31] ? wide_neg[63:16] : wide[63:16];
          ddo_pkg::OP_RIGHT_ANGLE: ra     <= cr[31] ? wide_neg[63:16] : wide[63:16];
          ddo_pkg::OP_LEFT_MAG:    wl     <= wide[63:0];
          ddo_pkg::OP_RIGHT_MAG:   wr     <= wide[63:0];
          default:                 plo    <= plo;
        endcase
      end
      default: plo <= plo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == ddo_pkg::ST_FIN && (!result.valid || result.ready)) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ddo_pkg::ST_FIN && (!result.valid || result.ready)) begin
      result.data.pose_x      <= acc_x[63:16];
      result.data.pose_y      <= acc_y[63:16];
      result.data.heading     <= acc_heading[39:8];
      result.data.quat_z      <= to_q15(sin_q30);
      result.data.quat_w      <= to_q15(cos_q30);
      result.data.linear_rate <= held[0];
      result.data.turn_rate   <= held[1];
      result.data.left_angle  <= la;
      result.data.right_angle <= ra;
      result.data.left_rate   <= held[2];
      result.data.right_rate  <= held[3];
      result.data.rates_fresh <= fresh;
    end
  end

  ddo_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (cordic_angle),
    .busy    (cordic_busy),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  ddo_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dt),
    .busy     (div_busy),
    .quotient (quotient)
  );

`ifndef NO_ASSERTIONS
  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample.ready)
    else $error("sample taken while a sample is in flight");

  a_cordic_free: assert property (@(posedge clk) disable iff (rst)
    cordic_start |-> !cordic_busy)
    else $error("CORDIC restarted while busy");

  a_rates_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == ddo_pkg::ST_DIV || state == ddo_pkg::ST_RSAT) |-> fresh)
    else $error("rate division with zero elapsed time");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy && dt != 32'd0)
    else $error("divider started while busy or with zero divisor");
`endif

endmodule

// ===== hw/rtl/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine in signed Q3.30 of a binary angle.
module ddo_cordic #(
  parameter int STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               busy,
  output logic signed [33:0] cos_q30,
  output logic signed [33:0] sin_q30
);

  logic signed [33:0] x, y, z;
  logic               flip;
  logic [5:0]         cnt;
  logic signed [33:0] za, zf, xs, ys;
  logic               fold;
  logic [31:0]        step_angle;

  always_comb begin
    za   = 34'(angle);
    zf   = za;
    fold = 1'b0;
    if (za > 34'sd1073741824) begin
      zf   = za - 34'sd2147483648;
      fold = 1'b1;
    end else if (za < -34'sd1073741824) begin
      zf   = za + 34'sd2147483648;
      fold = 1'b1;
    end
    xs         = x >>> cnt[4:0];
    ys         = y >>> cnt[4:0];
    step_angle = ddo_pkg::atan_turn(cnt[4:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      x    <= ddo_pkg::CORDIC_GAIN_Q30;
      y    <= '0;
      z    <= zf;
      flip <= fold;
    end else if (busy) begin
      if (cnt == 6'(STEPS)) begin
        cos_q30 <= flip ? -x : x;
        sin_q30 <= flip ? -y : y;
        busy    <= 1'b0;
      end else begin
        if (!z[33]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - $signed({2'b00, step_angle});
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + $signed({2'b00, step_angle});
        end
        cnt <= cnt + 6'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/ddo_divider.sv =====
// Restoring radix-2 divider of a 64-bit dividend by a 32-bit divisor, one bit per cycle.
module ddo_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic [32:0] trial;
  logic        take;

  always_comb begin
    trial = {rem, quotient[63]};
    take  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= 7'd64;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? 32'(trial - {1'b0, dvs}) : trial[31:0];
      quotient <= {quotient[62:0], take};
      cnt      <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
